// ----- src/nks_pkg.sv -----
// Shared constants, record layout and controller/datapath interface types
// for the nearest-k sorted insert block. No dependencies.
`default_nettype none

package nks_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = IDX_W + 1;
    localparam int RANK_W      = 6;

    localparam int DIST_W      = 20;
    localparam int IDENT_W     = 48;
    localparam int FLIGHT_W    = 64;
    localparam int TYPE_W      = 32;
    localparam int LAT_W       = 25;
    localparam int LON_W       = 26;
    localparam int SPEED_W     = 11;
    localparam int HEAD_W      = 9;
    localparam int ALT_W       = 18;

    // First member is the most significant: distance lands in the lowest bits.
    typedef struct packed {
        logic signed [ALT_W-1:0]   altitude;
        logic [HEAD_W-1:0]         heading;
        logic [SPEED_W-1:0]        speed;
        logic signed [LON_W-1:0]   longitude;
        logic signed [LAT_W-1:0]   latitude;
        logic [TYPE_W-1:0]         type_label;
        logic [FLIGHT_W-1:0]       flight_label;
        logic [IDENT_W-1:0]        ident;
        logic [DIST_W-1:0]         distance;
    } t_rec;

    localparam int REC_W       = $bits(t_rec);
    localparam int S_TDATA_W   = ((REC_W + 7) / 8) * 8;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = ((REC_W + RANK_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - REC_W - RANK_W;
    localparam int M_TUSER_W   = 1;

    localparam int S_USER_FIRST = 0;
    localparam int S_USER_HAS   = 1;

    typedef struct packed {
        logic cap;
        logic scan_start;
        logic scan_step;
        logic put0;
        logic emit_clr;
        logic emit_rd;
        logic emit_ld;
        logic emit_none;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic greater;
        logic idx_zero;
        logic out_free;
        logic emit_final;
        logic last_flag;
        logic has_flag;
    } t_stat;

endpackage

`default_nettype wire

// ----- src/nearest_k_sorted_insert.sv -----
// Top level of the nearest-k sorted insert block: joins controller and datapath.
// Depends on nks_pkg, nks_ctrl and nks_dpath.
//
// Keeps the MAX_ENTRIES nearest records of a list in ascending distance, ties
// in arrival order, and on the item marked last streams them out nearest
// first (one item with tuser 0 if the list is empty). One input item is taken
// at a time: a marker-only item is captured and dispatched; a record is also
// placed by the tail-to-front shift loop, which reads and writes one memory
// entry per cycle and shifts one step for each stored entry farther than it.
// Emitting reads each entry through the single read port, then loads it into
// the output register, waiting whenever m_tready holds that register full;
// s_tready returns once the last result sits in the output register.
`default_nettype none

module nearest_k_sorted_insert
    import nks_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // distance, ident, flight_label, type_label, latitude, longitude,
    // ground_speed, heading, altitude
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // first, has_record
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    // last
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // rank, out_distance, out_ident, out_flight_label, out_type_label,
    // out_latitude, out_longitude, out_ground_speed, out_heading, out_altitude
    output logic [M_TDATA_W-1:0]      m_tdata,
    // entry_valid
    output logic [M_TUSER_W-1:0]      m_tuser,
    // final_res
    output logic                      m_tlast
);

    t_cmd  cmd;
    t_stat stat;

    nks_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    nks_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ----- src/nks_ctrl.sv -----
// Controller state machine for the nearest-k sorted insert block.
// Depends on nks_pkg; drives the datapath through t_cmd, reads t_stat.
`default_nettype none

module nks_ctrl
    import nks_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_s_tvalid,
    output logic       o_s_tready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DISP   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_PUT0   = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;
    localparam logic [2:0] S_E_RD   = 3'd5;
    localparam logic [2:0] S_E_LD   = 3'd6;
    localparam logic [2:0] S_E_NONE = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.cap = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stat.has_flag) begin
                    if (i_stat.count_zero) begin
                        n_state = S_PUT0;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end else if (i_stat.last_flag) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.greater && !i_stat.idx_zero) begin
                    n_state = S_SCAN;
                end else if (i_stat.greater) begin
                    n_state = S_PUT0;
                end else begin
                    n_state = i_stat.last_flag ? S_EMIT : S_IDLE;
                end
            end
            S_PUT0: begin
                o_cmd.put0 = 1'b1;
                n_state    = i_stat.last_flag ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_stat.count_zero) begin
                    n_state = S_E_NONE;
                end else begin
                    o_cmd.emit_clr = 1'b1;
                    n_state        = S_E_RD;
                end
            end
            S_E_RD: begin
                o_cmd.emit_rd = 1'b1;
                n_state       = S_E_LD;
            end
            S_E_LD: begin
                o_cmd.emit_ld = 1'b1;
                if (i_stat.out_free) begin
                    n_state = i_stat.emit_final ? S_IDLE : S_E_RD;
                end
            end
            S_E_NONE: begin
                o_cmd.emit_none = 1'b1;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- src/nks_dpath.sv -----
// Datapath of the nearest-k sorted insert block: entry memory, count, index,
// record holding register and output register. Depends on nks_pkg.
`default_nettype none

module nks_dpath
    import nks_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_stat                     o_stat,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    input  wire logic [S_TUSER_W-1:0] i_s_tuser,
    input  wire logic                 i_s_tlast,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [M_TDATA_W-1:0]      o_m_tdata,
    output logic [M_TUSER_W-1:0]      o_m_tuser,
    output logic                      o_m_tlast
);

    t_rec             mem [MAX_ENTRIES];
    t_rec             r_rdata;
    t_rec             r_rec;
    logic             r_last;
    logic             r_has;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_idx;

    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic [M_TUSER_W-1:0] r_out_user;
    logic                 r_out_last;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_rec             wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;

    logic [CNT_W-1:0] idx_hi;
    logic [CNT_W-1:0] cnt_m1;
    logic             hi_ok;
    logic             greater;
    logic             idx_zero;
    logic             out_free;
    logic             emit_final;
    logic             ld_entry;
    logic             ld_none;
    logic             ins_done;

    assign idx_hi     = {1'b0, r_idx} + CNT_W'(1);
    assign cnt_m1     = r_count - CNT_W'(1);
    assign hi_ok      = idx_hi < CNT_W'(MAX_ENTRIES);
    assign greater    = r_rdata.distance > r_rec.distance;
    assign idx_zero   = (r_idx == '0);
    assign out_free   = !r_out_valid || i_m_tready;
    assign emit_final = (idx_hi == r_count);
    assign ld_entry   = i_cmd.emit_ld && out_free;
    assign ld_none    = i_cmd.emit_none && out_free;
    assign ins_done   = (i_cmd.scan_step && !greater) || i_cmd.put0;

    always_comb begin
        o_stat.count_zero = (r_count == '0);
        o_stat.greater    = greater;
        o_stat.idx_zero   = idx_zero;
        o_stat.out_free   = out_free;
        o_stat.emit_final = emit_final;
        o_stat.last_flag  = r_last;
        o_stat.has_flag   = r_has;
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = r_rec;
        rd_en   = 1'b0;
        rd_addr = r_idx;
        if (i_cmd.scan_start) begin
            rd_en   = 1'b1;
            rd_addr = cnt_m1[IDX_W-1:0];
        end
        if (i_cmd.scan_step) begin
            wr_en   = hi_ok;
            wr_addr = idx_hi[IDX_W-1:0];
            if (greater) begin
                wr_data = r_rdata;
                if (!idx_zero) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx - IDX_W'(1);
                end
            end
        end
        if (i_cmd.put0) begin
            wr_en   = 1'b1;
            wr_addr = '0;
        end
        if (i_cmd.emit_rd) begin
            rd_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_rec <= i_s_tdata[REC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
            r_last  <= 1'b0;
            r_has   <= 1'b0;
        end else begin
            if (i_cmd.cap) begin
                r_last <= i_s_tlast;
                r_has  <= i_s_tuser[S_USER_HAS];
                if (i_s_tuser[S_USER_FIRST]) begin
                    r_count <= '0;
                end
            end else if (ins_done && (r_count != CNT_W'(MAX_ENTRIES))) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.scan_start) begin
                r_idx <= cnt_m1[IDX_W-1:0];
            end else if (i_cmd.scan_step && greater && !idx_zero) begin
                r_idx <= r_idx - IDX_W'(1);
            end else if (i_cmd.emit_clr) begin
                r_idx <= '0;
            end else if (ld_entry && !emit_final) begin
                r_idx <= idx_hi[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld_entry || ld_none) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_entry) begin
            r_out_data <= {{M_PAD_W{1'b0}}, r_rdata, RANK_W'(r_idx)};
            r_out_user <= M_TUSER_W'(1);
            r_out_last <= emit_final;
        end else if (ld_none) begin
            r_out_data <= '0;
            r_out_user <= '0;
            r_out_last <= 1'b1;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

// ----- src/nks_checker.sv -----
// Port-level checks for the nearest-k sorted insert block, bound to the top.
// Depends on nks_pkg and nearest_k_sorted_insert.
`default_nettype none

module nks_checker
    import nks_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [M_TUSER_W-1:0] m_tuser,
    input wire logic                 m_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    a_empty_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == '0))
        else $error("empty-list item not final or not zero");

    a_rank_zero_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tready && m_tlast ##1 m_tvalid && m_tuser[0]
        |-> m_tdata[RANK_W-1:0] == '0)
        else $error("new run does not start at rank zero");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind nearest_k_sorted_insert nks_checker u_nks_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
